// ----- rtl/frpr_pkg.sv -----
// Package for the framed packet receiver: configuration and result types,
// register index codes, event codes and the byte-wide CRC-16-CCITT update.
// No dependencies.
package frpr_pkg;

  localparam int unsigned HEADER_BYTES    = 7;
  localparam int unsigned LIMIT_W         = 11;
  localparam int unsigned LIMIT_CEIL      = 2047;
  localparam int unsigned CFG_IDX_W       = 3;
  localparam int unsigned CFG_DATA_W      = 16;
  localparam int unsigned DEF_MAX_PAYLOAD = 1024;
  localparam logic [15:0] CCITT_POLY      = 16'h1021;
  localparam int unsigned OUT_DATA_W      = 96;
  localparam int unsigned OUT_USER_W      = 3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAGIC_FIRST  = 3'd0,
    REG_MAGIC_SECOND = 3'd1,
    REG_CMD_START    = 3'd2,
    REG_CMD_DATA     = 3'd3,
    REG_CMD_END      = 3'd4,
    REG_CMD_ABORT    = 3'd5,
    REG_PAYLOAD_LIM  = 3'd6,
    REG_CRC_SEED     = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_PAYLOAD   = 3'd1,
    EV_GOOD      = 3'd2,
    EV_BAD_CMD   = 3'd3,
    EV_OVERSIZE  = 3'd4,
    EV_CRC_ERR   = 3'd5
  } event_t;

  typedef struct packed {
    logic [7:0]         magic_first;
    logic [7:0]         magic_second;
    logic [7:0]         cmd_start;
    logic [7:0]         cmd_data;
    logic [7:0]         cmd_end;
    logic [7:0]         cmd_abort;
    logic [LIMIT_W-1:0] payload_limit;
    logic [15:0]        crc_seed;
  } cfg_t;

  typedef struct packed {
    event_t      kind;
    logic [7:0]  payload_byte;
    logic [9:0]  payload_index;
    logic [7:0]  command_code;
    logic [15:0] sequence_number;
    logic [15:0] payload_length;
    logic [15:0] crc_received;
    logic [15:0] crc_computed;
  } result_t;

  // One byte into CRC-16-CCITT, MSB first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CCITT_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/framed_packet_receiver_crc16.sv -----
// Framed packet receiver with CRC-16-CCITT check, one received byte per transaction.
// Each input transaction's result is registered in the output register as the byte is accepted.
// Throughput: 1 byte per cycle while the consumer takes results; the output register refills while it drains.
// Every input transaction yields exactly one output transaction (often kind "nothing").
// Reset (rst_n low, synchronous): hunt for the first magic byte, CRC = 0xFFFF,
// output empty, configuration registers back to their defaults.
module framed_packet_receiver_crc16
  import frpr_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = DEF_MAX_PAYLOAD
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input stream; tdata: rx_byte[7:0]
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,
  // Result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // tdata: payload_byte[7:0], payload_index[17:8], command_code[25:18],
  //        sequence_number[41:26], payload_length[57:42], crc_received[73:58],
  //        crc_computed[89:74], zero fill[95:90]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // tuser: event_kind[2:0]
  output logic [OUT_USER_W-1:0] out_tuser,
  // Configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t    cfg;
  result_t core_result;
  result_t held_result;
  logic    can_load;
  logic    in_fire;

  // Take a byte whenever the result register is empty or draining this cycle
  assign in_tready = can_load;
  assign in_fire   = in_tvalid && in_tready;

  frpr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Frame position, held header, running CRC; advance once per accepted byte
  frpr_core #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (in_fire),
    .rx_byte (in_tdata),
    .cfg     (cfg),
    .result  (core_result)
  );

  // Hold the result until the consumer takes it
  frpr_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (in_fire),
    .result     (core_result),
    .can_load   (can_load),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_result (held_result)
  );

  assign out_tuser = held_result.kind;
  assign out_tdata = {6'b0,
                      held_result.crc_computed,
                      held_result.crc_received,
                      held_result.payload_length,
                      held_result.sequence_number,
                      held_result.command_code,
                      held_result.payload_index,
                      held_result.payload_byte};

endmodule

// ----- rtl/frpr_cfg_regs.sv -----
// Configuration register bank of the framed packet receiver.
// Depends on frpr_pkg.
module frpr_cfg_regs
  import frpr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.magic_first   <= 8'hAA;
      cfg_r.magic_second  <= 8'h55;
      cfg_r.cmd_start     <= 8'd1;
      cfg_r.cmd_data      <= 8'd2;
      cfg_r.cmd_end       <= 8'd3;
      cfg_r.cmd_abort     <= 8'd4;
      cfg_r.payload_limit <= LIMIT_W'(1024);
      cfg_r.crc_seed      <= 16'hFFFF;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_MAGIC_FIRST:  cfg_r.magic_first   <= cfg_wdata[7:0];
        REG_MAGIC_SECOND: cfg_r.magic_second  <= cfg_wdata[7:0];
        REG_CMD_START:    cfg_r.cmd_start     <= cfg_wdata[7:0];
        REG_CMD_DATA:     cfg_r.cmd_data      <= cfg_wdata[7:0];
        REG_CMD_END:      cfg_r.cmd_end       <= cfg_wdata[7:0];
        REG_CMD_ABORT:    cfg_r.cmd_abort     <= cfg_wdata[7:0];
        REG_PAYLOAD_LIM:  cfg_r.payload_limit <= cfg_wdata[LIMIT_W-1:0];
        REG_CRC_SEED:     cfg_r.crc_seed      <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- rtl/frpr_core.sv -----
// Frame tracking state and per-byte decode of the framed packet receiver.
// Depends on frpr_pkg.
module frpr_core
  import frpr_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = DEF_MAX_PAYLOAD
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] rx_byte,
  input  cfg_t       cfg,
  output result_t    result
);

  localparam int unsigned LEN_BOUND = (MAX_PAYLOAD < LIMIT_CEIL) ? MAX_PAYLOAD : LIMIT_CEIL;
  localparam int unsigned POS_W     = $clog2(LEN_BOUND + HEADER_BYTES + 2);
  localparam logic [16:0] MAX_LEN17 = 17'(MAX_PAYLOAD);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       cmd_r, cmd_nxt;
  logic [15:0]      seq_r, seq_nxt;
  logic [15:0]      len_r, len_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [7:0]       tlow_r, tlow_nxt;

  logic [15:0] crc_fed;
  logic [15:0] crc_seeded;
  logic [15:0] pidx;
  logic [16:0] limit17;
  logic [15:0] crc_rx;
  logic        cmd_ok;
  logic        header_out;
  logic        crc_out;

  assign crc_fed    = crc16_byte(crc_r, rx_byte);
  assign crc_seeded = crc16_byte(cfg.crc_seed, rx_byte);
  assign pidx       = 16'(pos_r) - 16'(HEADER_BYTES);
  assign limit17    = (17'(cfg.payload_limit) > MAX_LEN17) ? MAX_LEN17 : 17'(cfg.payload_limit);
  assign crc_rx     = {rx_byte, tlow_r};
  assign cmd_ok     = (cmd_r == cfg.cmd_start) || (cmd_r == cfg.cmd_data) ||
                      (cmd_r == cfg.cmd_end) || (cmd_r == cfg.cmd_abort);

  always_comb begin
    pos_nxt    = pos_r;
    cmd_nxt    = cmd_r;
    seq_nxt    = seq_r;
    len_nxt    = len_r;
    crc_nxt    = crc_r;
    tlow_nxt   = tlow_r;
    header_out = 1'b0;
    crc_out    = 1'b0;
    result     = '0;
    result.kind = EV_NONE;

    if (pos_r == POS_W'(0)) begin
      if (rx_byte == cfg.magic_first) begin
        crc_nxt = crc_seeded;
        pos_nxt = POS_W'(1);
      end
    end else if (pos_r == POS_W'(1)) begin
      if (rx_byte == cfg.magic_second) begin
        crc_nxt = crc_fed;
        pos_nxt = POS_W'(2);
      end else if (rx_byte == cfg.magic_first) begin
        crc_nxt = crc_seeded;
      end else begin
        crc_nxt = cfg.crc_seed;
        pos_nxt = '0;
      end
    end else if (pos_r < POS_W'(HEADER_BYTES)) begin
      crc_nxt = crc_fed;
      pos_nxt = pos_r + POS_W'(1);
      case (pos_r)
        POS_W'(2): cmd_nxt = rx_byte;
        POS_W'(3): seq_nxt = {8'h00, rx_byte};
        POS_W'(4): seq_nxt = {rx_byte, seq_r[7:0]};
        POS_W'(5): len_nxt = {8'h00, rx_byte};
        default: begin
          len_nxt = {rx_byte, len_r[7:0]};
          // Oversize length: report at the last header byte and resync
          if ({1'b0, len_nxt} > limit17) begin
            result.kind = EV_OVERSIZE;
            header_out  = 1'b1;
            pos_nxt     = '0;
            crc_nxt     = cfg.crc_seed;
          end
        end
      endcase
    end else if (pidx < len_r) begin
      crc_nxt              = crc_fed;
      pos_nxt              = pos_r + POS_W'(1);
      result.kind          = EV_PAYLOAD;
      result.payload_byte  = rx_byte;
      result.payload_index = pidx[9:0];
      header_out           = 1'b1;
    end else if (pidx == len_r) begin
      tlow_nxt = rx_byte;
      pos_nxt  = pos_r + POS_W'(1);
    end else begin
      // Trailer high byte: bad command outranks CRC mismatch
      if (!cmd_ok) begin
        result.kind = EV_BAD_CMD;
      end else if (crc_rx == crc_r) begin
        result.kind = EV_GOOD;
      end else begin
        result.kind = EV_CRC_ERR;
      end
      header_out = 1'b1;
      crc_out    = 1'b1;
      pos_nxt    = '0;
      crc_nxt    = cfg.crc_seed;
    end

    if (header_out) begin
      result.command_code    = cmd_nxt;
      result.sequence_number = seq_nxt;
      result.payload_length  = len_nxt;
    end
    if (crc_out) begin
      result.crc_received = crc_rx;
      result.crc_computed = crc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      cmd_r  <= '0;
      seq_r  <= '0;
      len_r  <= '0;
      crc_r  <= 16'hFFFF;
      tlow_r <= '0;
    end else if (step) begin
      pos_r  <= pos_nxt;
      cmd_r  <= cmd_nxt;
      seq_r  <= seq_nxt;
      len_r  <= len_nxt;
      crc_r  <= crc_nxt;
      tlow_r <= tlow_nxt;
    end
  end

endmodule

// ----- rtl/frpr_out_reg.sv -----
// Result register of the framed packet receiver: holds one result until the
// downstream side takes it, and refills in the same cycle it drains.
// Depends on frpr_pkg.
module frpr_out_reg
  import frpr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t result,
  output logic    can_load,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_result
);

  logic    valid_r;
  result_t data_r;

  assign can_load = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result;
    end
  end

  assign out_valid  = valid_r;
  assign out_result = data_r;

endmodule
